// File: design/lkc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkc_pkg: shared types and constants for the lru key cache
// beat payloads, the per-cell command bundle and the cell-to-cell link
// ----------------------------------------------------------------------------
package lkc_pkg;

   localparam int KEY_W         = 16;
   localparam int CNT_W         = 5;
   localparam int ENTRIES_DFLT  = 16;
   localparam int ADDR_W        = 3;
   localparam int DATA_W        = 32;

   localparam logic [CNT_W-1:0] CAPACITY_RST = CNT_W'(10);

   // register indexes, taken from paddr[2]
   localparam logic REG_CAPACITY = 1'b0;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic             in_backing_store;
   } req_type;

   typedef struct packed {
      logic             hit;
      logic             filled;
      logic             evicted;
      logic [KEY_W-1:0] evicted_key;
      logic [CNT_W-1:0] occupancy;
   } rsp_type;

   // broadcast to every cell
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic             hit;
      logic             fill;
      logic [CNT_W-1:0] limit;
      logic [CNT_W-1:0] count;
   } cmd_type;

   // handed from one cell to the next
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic             found;
      logic [KEY_W-1:0] ev_key;
   } link_type;

endpackage

// File: design/lkc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkc_cell: one slot of the recency chain
// holds one key, compares it, and shifts in its left neighbor's key on command
// ----------------------------------------------------------------------------
module lkc_cell #(
   parameter int IDX = 0
) (
   input  logic              clock,
   input  lkc_pkg::cmd_type  cmd,
   input  lkc_pkg::link_type link_in,
   output lkc_pkg::link_type link_out
);

   logic [lkc_pkg::KEY_W-1:0] key_ff;
   logic [lkc_pkg::KEY_W-1:0] key_in;
   logic                      valid;
   logic                      match;
   logic                      last;
   logic                      load;

   always_comb begin
      valid = IDX < int'(cmd.count);
      last  = (IDX + 1) == int'(cmd.count);
      match = valid && (key_ff == cmd.key);
      // hit: slots up to the matching one move back; fill: slots up to limit
      load  = (cmd.hit && !link_in.found) || (cmd.fill && (IDX <= int'(cmd.limit)));
      key_in = load ? link_in.key : key_ff;

      link_out.key    = key_ff;
      link_out.found  = link_in.found | match;
      link_out.ev_key = link_in.ev_key | (last ? key_ff : '0);
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

// File: design/lru_key_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_cache: least-recently-used key cache
// keeps up to capacity keys most recent first in a row of shifting cells
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low. Busy is high
// for the one cycle in which the whole row of cells compares the key and
// shifts, and the result beat is shown on the rsp_ ports with rsp_valid for
// exactly one cycle after that, so a new request can be taken in the same
// cycle the previous result is shown. The result cannot
// be held off and must be captured when rsp_valid is high. On a hit the key
// moves to the front; on a miss with in_backing_store set it is inserted at
// the front, evicting the least recent key if occupancy has reached capacity.
// Capacity (register 0, reset 10) acts as 1 when written 0 and as ENTRIES
// when written larger; lowering it drops nothing at once. Write it only while
// idle. Slots hold no reset value; only resident slots are ever looked at.
// ----------------------------------------------------------------------------
module lru_key_cache #(
   parameter int ENTRIES = lkc_pkg::ENTRIES_DFLT
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        start,
   output logic                        busy,
   input  lkc_pkg::req_type            req_data,
   // result channel
   output logic                        rsp_valid,
   output lkc_pkg::rsp_type            rsp_data,
   // register port
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [lkc_pkg::ADDR_W-1:0]  paddr,
   input  logic [lkc_pkg::DATA_W-1:0]  pwdata,
   output logic [lkc_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);

   localparam int CNT_W = lkc_pkg::CNT_W;

   // control state
   logic                  busy_ff,      busy_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]      cap_ff,       cap_in;
   logic [CNT_W-1:0]      count_ff,     count_in;
   // payload
   lkc_pkg::req_type      req_ff,       req_in;
   lkc_pkg::rsp_type      rsp_ff,       rsp_in;

   lkc_pkg::cmd_type      cmd;
   lkc_pkg::link_type     link [ENTRIES+1];

   logic                  accept;
   logic                  csr_wr;
   logic                  hit;
   logic                  fill;
   logic                  full;
   logic [CNT_W-1:0]      cap_eff;

   assign accept = start && !busy_ff;
   assign csr_wr = psel && penable && pwrite && (paddr[2] == lkc_pkg::REG_CAPACITY);

   // register port: always ready, one register
   assign pready = 1'b1;
   always_comb begin
      case (paddr[2])
         lkc_pkg::REG_CAPACITY: prdata = lkc_pkg::DATA_W'(cap_ff);
         default:               prdata = '0;
      endcase
   end

   // effective capacity: zero acts as one, clamp to the row length
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CNT_W'(1);
      end else if (int'(cap_ff) > ENTRIES) begin
         cap_eff = CNT_W'(ENTRIES);
      end else begin
         cap_eff = cap_ff;
      end
   end

   // head of the chain: request key enters cell 0, nothing found yet
   assign link[0].key    = req_ff.key;
   assign link[0].found  = 1'b0;
   assign link[0].ev_key = '0;

   // decision from the end of the compare chain
   assign hit  = link[ENTRIES].found;
   assign fill = !hit && req_ff.in_backing_store;
   assign full = count_ff >= cap_eff;

   // shift commands only act in the busy cycle
   always_comb begin
      cmd.key   = req_ff.key;
      cmd.count = count_ff;
      cmd.hit   = busy_ff && hit;
      cmd.fill  = busy_ff && fill;
      // evicting: last resident slot is dropped, so shift one short
      cmd.limit = full ? count_ff - CNT_W'(1) : count_ff;
   end

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      lkc_cell #(
         .IDX (i)
      ) u_cell (
         .clock    (clock),
         .cmd      (cmd),
         .link_in  (link[i]),
         .link_out (link[i+1])
      );
   end

   // next-state logic
   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = 1'b0;
      cap_in       = csr_wr ? pwdata[CNT_W-1:0] : cap_ff;
      count_in     = count_ff;
      req_in       = accept ? req_data : req_ff;
      rsp_in       = rsp_ff;

      if (busy_ff) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         if (fill && !full) begin
            count_in = count_ff + CNT_W'(1);
         end
         rsp_in.hit         = hit;
         rsp_in.filled      = fill;
         rsp_in.evicted     = fill && full;
         rsp_in.evicted_key = (fill && full) ? link[ENTRIES].ev_key : '0;
         rsp_in.occupancy   = count_in;
      end else if (accept) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= lkc_pkg::CAPACITY_RST;
         count_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         cap_ff       <= cap_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: design/lkc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkc_checker: port-level checks for the lru key cache
// request/result timing and consistency of the result flags
// ----------------------------------------------------------------------------
module lkc_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  lkc_pkg::req_type            req_data,
   input  logic                        rsp_valid,
   input  lkc_pkg::rsp_type            rsp_data,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [lkc_pkg::ADDR_W-1:0]  paddr,
   input  logic [lkc_pkg::DATA_W-1:0]  pwdata,
   input  logic [lkc_pkg::DATA_W-1:0]  prdata,
   input  logic                        pready
);

   // a taken beat makes the block busy next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy did not rise after request beat");

   // one busy cycle, then a result beat
   a_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_valid && !busy)
      else $error("result beat missing after busy cycle");

   // no result beat without a busy cycle in the cycle before
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result beat without request");

   a_evict_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.evicted |-> rsp_data.filled && !rsp_data.hit)
      else $error("eviction without fill");

   a_evkey_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.evicted |-> rsp_data.evicted_key == '0)
      else $error("evicted key not zero");

endmodule

bind lru_key_cache lkc_checker u_lkc_checker (.*);
